// ===== sv/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types for the slot pool allocator: the order-cell operations and
// the link that one order cell hands to its right-hand neighbour.
// ----------------------------------------------------------------------------
package spa_pkg;

    // Operation broadcast to every order cell in a cycle
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_APPEND  = 3'd1,
        OP_RECLAIM = 3'd2,
        OP_RELEASE = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    // Left-to-right hand-off between neighbouring cells
    typedef struct packed {
        logic valid;   // this cell holds a list entry
        logic shift;   // released entry sits here or further left
    } t_fwd_link;

endpackage

// ===== sv/spa_order_cell.sv =====
// ----------------------------------------------------------------------------
// spa_order_cell
// One position of the grant-order list: holds a slot number and a valid
// flag, and takes its right-hand neighbour's entry when the list closes up.
// ----------------------------------------------------------------------------
module spa_order_cell #(
    parameter int SLOT_W = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spa_pkg::t_op       i_op,
    input  logic [SLOT_W-1:0]  i_new_slot,
    input  logic [SLOT_W-1:0]  i_rel_slot,
    input  spa_pkg::t_fwd_link i_left,
    output spa_pkg::t_fwd_link o_right,
    input  logic               i_next_valid,
    input  logic [SLOT_W-1:0]  i_next_slot,
    output logic               o_valid,
    output logic [SLOT_W-1:0]  o_slot
);

    logic              r_valid;
    logic              n_valid;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              w_shift;

    // Close the gap from the released entry rightwards
    assign w_shift = (i_op == spa_pkg::OP_RELEASE) &&
                     (i_left.shift || (r_valid && (r_slot == i_rel_slot)));

    assign o_right.valid = r_valid;
    assign o_right.shift = w_shift;
    assign o_valid       = r_valid;
    assign o_slot        = r_slot;

    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        case (i_op)
            spa_pkg::OP_CLEAR: begin
                n_valid = 1'b0;
            end
            spa_pkg::OP_APPEND: begin
                // first empty cell takes the new tail entry
                if (!r_valid && i_left.valid) begin
                    n_valid = 1'b1;
                    n_slot  = i_new_slot;
                end
            end
            spa_pkg::OP_RECLAIM: begin
                // rotate: all entries move one left, the old head lands at the tail
                if (r_valid) begin
                    n_slot = i_next_valid ? i_next_slot : i_new_slot;
                end
            end
            spa_pkg::OP_RELEASE: begin
                if (w_shift) begin
                    if (i_next_valid) begin
                        n_slot = i_next_slot;
                    end else begin
                        n_valid = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

// ===== sv/slot_pool_allocator_oldest_reclaim.sv =====
// ----------------------------------------------------------------------------
// slot_pool_allocator_oldest_reclaim
// Fixed slot pool allocator that reclaims the oldest granted slot when full.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser is the action (0 allocate,
//   1 release) and tdata[3:0] the slot to release. Each request yields one
//   response transaction on m_axis: ok, granted slot and a reclaimed flag.
//   The pool size is written on the cfg channel (always ready); a write also
//   empties the pool. Write it only while no request is outstanding.
// Timing:
//   A request is answered in the cycle after acceptance; a new request can be
//   taken every cycle unless m_axis stalls: the lowest-free-slot search and
//   the grant-order cell row update both complete in the accepting cycle.
//   The response sits in an output register; while the receiver stalls with
//   a response pending, s_axis_tready is low and the requester is held.
// Reset:
//   Pool size returns to 16 (capped at POOL_DEPTH), every slot inactive and
//   the grant-order list empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module slot_pool_allocator_oldest_reclaim #(
    parameter int POOL_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write: slots_in_use
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data,
    // request stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] slot_index, [7:4] zero
    input  logic       s_axis_tuser,   // [0] action
    // response stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] ok, [4:1] granted_slot, [5] reclaimed,
                                       // [7:6] zero
);

    localparam int IW       = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int SW       = $clog2(POOL_DEPTH + 1);
    localparam int RST_SIZE = (POOL_DEPTH < 16) ? POOL_DEPTH : 16;

    // Pool state
    logic [SW-1:0]         r_size;
    logic [SW-1:0]         n_size;
    logic [POOL_DEPTH-1:0] r_active;
    logic [POOL_DEPTH-1:0] n_active;

    // Response register
    logic       r_out_valid;
    logic       n_out_valid;
    logic       r_ok;
    logic       n_ok;
    logic [3:0] r_granted;
    logic [3:0] n_granted;
    logic       r_recl;
    logic       n_recl;

    // Cell row
    spa_pkg::t_op       w_op;
    logic [IW-1:0]      w_new_slot;
    logic [IW-1:0]      w_rel_slot;
    spa_pkg::t_fwd_link w_link  [POOL_DEPTH+1];
    logic               w_cvalid [POOL_DEPTH];
    logic [IW-1:0]      w_cslot  [POOL_DEPTH];

    logic          w_accept;
    logic          w_free_found;
    logic [IW-1:0] w_free_idx;
    logic          w_rel_ok;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_recl, r_granted, r_ok};

    // Release target, resized to the slot number width
    assign w_rel_slot = IW'(32'(s_axis_tdata[3:0]));

    // Lowest inactive slot within the current pool size
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int s = 0; s < POOL_DEPTH; s++) begin
            if (!w_free_found && (32'(s) < 32'(r_size)) && !r_active[s]) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(s);
            end
        end
    end

    assign w_rel_ok = (32'(s_axis_tdata[3:0]) < 32'(r_size)) && r_active[w_rel_slot];

    // Decode the transaction into a cell operation and a response
    always_comb begin
        n_size      = r_size;
        n_active    = r_active;
        n_out_valid = r_out_valid;
        n_ok        = r_ok;
        n_granted   = r_granted;
        n_recl      = r_recl;
        w_op        = spa_pkg::OP_NONE;
        w_new_slot  = w_free_idx;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            // cap at the pool depth and empty the pool
            if (32'(i_cfg_data) > 32'(POOL_DEPTH)) begin
                n_size = SW'(POOL_DEPTH);
            end else begin
                n_size = SW'(32'(i_cfg_data));
            end
            n_active = '0;
            w_op     = spa_pkg::OP_CLEAR;
        end else if (w_accept) begin
            n_out_valid = 1'b1;
            n_ok        = 1'b0;
            n_granted   = '0;
            n_recl      = 1'b0;
            if (!s_axis_tuser) begin
                if (w_free_found) begin
                    w_op                 = spa_pkg::OP_APPEND;
                    n_active[w_free_idx] = 1'b1;
                    n_ok                 = 1'b1;
                    n_granted            = 4'(32'(w_free_idx));
                end else if (w_cvalid[0]) begin
                    // pool full: rotate the oldest grant to the tail
                    w_op       = spa_pkg::OP_RECLAIM;
                    w_new_slot = w_cslot[0];
                    n_ok       = 1'b1;
                    n_granted  = 4'(32'(w_cslot[0]));
                    n_recl     = 1'b1;
                end
            end else if (w_rel_ok) begin
                w_op                 = spa_pkg::OP_RELEASE;
                n_active[w_rel_slot] = 1'b0;
                n_ok                 = 1'b1;
            end
        end
    end

    // Head of the row: always "valid" to its right, nothing released before it
    assign w_link[0].valid = 1'b1;
    assign w_link[0].shift = 1'b0;

    for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
        logic          w_next_valid;
        logic [IW-1:0] w_next_slot;

        if (g == POOL_DEPTH - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_slot  = '0;
        end else begin : g_mid
            assign w_next_valid = w_cvalid[g+1];
            assign w_next_slot  = w_cslot[g+1];
        end

        spa_order_cell #(
            .SLOT_W (IW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_new_slot   (w_new_slot),
            .i_rel_slot   (w_rel_slot),
            .i_left       (w_link[g]),
            .o_right      (w_link[g+1]),
            .i_next_valid (w_next_valid),
            .i_next_slot  (w_next_slot),
            .o_valid      (w_cvalid[g]),
            .o_slot       (w_cslot[g])
        );
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SW'(RST_SIZE);
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_size      <= n_size;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        r_ok      <= n_ok;
        r_granted <= n_granted;
        r_recl    <= n_recl;
    end

endmodule
